@@ design/lpp_pkg.sv @@
// Shared types and constants of the locked page pool.
`default_nettype none
package lpp_pkg;

  typedef enum logic [2:0] {
    OP_GET_VALID = 3'd0,
    OP_GET_EMPTY = 3'd1,
    OP_PUT_VALID = 3'd2,
    OP_PUT_EMPTY = 3'd3,
    OP_FIND      = 3'd4
  } op_e;

  localparam logic [2:0] CFG_PAGE_COUNT  = 3'd0;
  localparam logic [2:0] CFG_PAGE_SHIFT  = 3'd1;
  localparam logic [2:0] CFG_PROBE_MUL   = 3'd2;
  localparam logic [2:0] CFG_PROBE_INC   = 3'd3;
  localparam logic [2:0] CFG_PROBE_MOD   = 3'd4;
  localparam logic [2:0] CFG_METRIC_MODE = 3'd5;

  localparam logic [63:0] RAND_MUL   = 64'd2862933555777941757;
  localparam logic [63:0] RAND_ADD   = 64'd3037000493;
  localparam logic [63:0] SEED_RESET = 64'h0000_0000_0000_beef;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SEED0,
    ST_SEED1,
    ST_SEED2,
    ST_SEED3,
    ST_START,
    ST_START_W,
    ST_IDX,
    ST_IDX_W,
    ST_RD,
    ST_CHK,
    ST_STEP_MUL,
    ST_STEP_MOD,
    ST_STEP_MOD_W,
    ST_FIXQ,
    ST_FIXQ_W,
    ST_ADV,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_FIN
  } state_e;

  // request to the shared remainder unit
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [6:0]  nbits;
    logic [11:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic        ok;
    logic [9:0]  entry_index;
    logic [15:0] pattern_id;
    logic [31:0] tag;
    logic [31:0] touch;
    logic [63:0] offset;
    logic [63:0] phys_addr;
  } res_t;

endpackage
`default_nettype wire

@@ design/locked_page_pool_random_probe_unit.sv @@
// Top level of the locked page pool: sequencer, entry table and registers.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o  | opcode .. lookup_address
//   out     | output    | out_valid_o / out_ready_i| ok .. phys_addr
//   cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// Put, if accepted, writes its entry in the decode state. Find reads and checks the entries in order.
// Get draws a seed and takes the start remainder, then per probe computes the
// index, reads and checks the entry and takes probe-order steps (steps are
// rejected while they land outside the pool) on the bit-serial remainder unit.
// After reset a clearing pass locks every entry before requests are taken.
// A finished result waits in the output register; the next request is taken meanwhile.
`default_nettype none
module locked_page_pool_random_probe_unit #(
  parameter int MAX_PAGES       = 1024,
  parameter int PATTERN_ID_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic        use_tag_mask_i,
  input  wire logic [31:0] tag_mask_i,
  input  wire logic [15:0] new_pattern_id_i,
  input  wire logic [31:0] new_tag_i,
  input  wire logic [31:0] new_touch_i,
  input  wire logic [63:0] new_offset_i,
  input  wire logic [63:0] new_phys_addr_i,
  input  wire logic [63:0] lookup_address_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             ok_o,
  output logic [9:0]       entry_index_o,
  output logic [15:0]      pattern_id_o,
  output logic [31:0]      tag_o,
  output logic [31:0]      touch_o,
  output logic [63:0]      offset_o,
  output logic [63:0]      phys_addr_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [11:0] cfg_wdata_i
);
  import lpp_pkg::*;

  localparam int IdxW  = MAX_PAGES > 1 ? $clog2(MAX_PAGES) : 1;
  localparam int PidW  = PATTERN_ID_BITS < 16 ? PATTERN_ID_BITS : 16;
  localparam int QCap  = MAX_PAGES < 2047 ? MAX_PAGES : 2047;
  localparam int WordW = 1 + PidW + 192;
  localparam int PidLo = 192;

  // configuration
  logic [10:0] page_count_q;
  logic [5:0]  page_shift_q;
  logic [11:0] probe_mul_q, probe_inc_q, probe_mod_q;
  logic        metric_mode_q;

  state_e state_q, state_d;

  logic [IdxW-1:0] clr_q;
  logic [63:0]     seed_q, acc_q;
  logic [10:0]     start_q, i_q;
  logic [11:0]     n_q, k_q;
  logic [IdxW-1:0] idx_q;
  res_t            res_q, out_q;
  logic            out_valid_q;

  // latched request
  logic [2:0]  op_q;
  logic        use_mask_q;
  logic [31:0] mask_q, ntag_q, ntouch_q;
  logic [15:0] npid_q;
  logic [63:0] noff_q, nphys_q, laddr_q;

  // shared units
  logic            ram_we;
  logic [IdxW-1:0] ram_addr;
  logic [WordW-1:0] ram_wdata, ram_rdata;
  logic [31:0]     mul_a, mul_b;
  logic [63:0]     mul_p;
  mod_req_t        mod_req;
  logic            mod_done;
  logic [11:0]     mod_rem;
  logic            out_load;

  lpp_ram #(.Width(WordW), .Depth(MAX_PAGES)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  lpp_mul u_mul (.clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .p_o(mul_p));

  lpp_mod u_mod (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mod_req),
    .done_o(mod_done),
    .rem_o (mod_rem)
  );

  // derived values
  logic [10:0] q;
  logic [11:0] m;
  assign q = (page_count_q > 11'(QCap)) ? 11'(QCap) : page_count_q;
  assign m = (probe_mod_q == 12'd0) ? 12'd1 : probe_mod_q;

  logic            rd_lock;
  logic [PidW-1:0] rd_pid;
  logic [31:0]     rd_tag, rd_touch;
  logic [63:0]     rd_off, rd_phys;
  assign rd_lock  = ram_rdata[WordW-1];
  assign rd_pid   = ram_rdata[PidLo +: PidW];
  assign rd_tag   = ram_rdata[191:160];
  assign rd_touch = ram_rdata[159:128];
  assign rd_off   = ram_rdata[127:64];
  assign rd_phys  = ram_rdata[63:0];

  logic want_valid, get_hit;
  assign want_valid = (op_q == OP_GET_VALID);
  assign get_hit = ((rd_pid != '0) == want_valid)
                   && (!use_mask_q || ((rd_tag & mask_q) != 32'd0)) && !rd_lock;

  logic [63:0] diff;
  logic        find_hit;
  assign diff     = laddr_q - rd_phys;
  assign find_hit = (rd_phys <= laddr_q) && ((diff >> page_shift_q) == 64'd0);

  logic [PidW-1:0] put_pid;
  logic [63:0]     put_shift;
  logic            put_ok;
  assign put_pid   = (op_q == OP_PUT_EMPTY) ? '0 : PidW'(npid_q);
  assign put_shift = noff_q >> page_shift_q;
  assign put_ok    = !((op_q == OP_PUT_VALID) && (put_pid == '0))
                     && (put_shift < {53'd0, q});

  logic [10:0] i_next;
  assign i_next = i_q + 11'd1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:    if (clr_q == IdxW'(MAX_PAGES - 1)) state_d = ST_IDLE;
      ST_IDLE:     if (in_valid_i) state_d = ST_DECODE;
      ST_DECODE: begin
        if (q == 11'd0) begin
          state_d = ST_FIN;
        end else begin
          case (op_q) inside
            OP_GET_VALID, OP_GET_EMPTY: state_d = ST_SEED0;
            OP_FIND:                    state_d = ST_FIND_RD;
            default:                    state_d = ST_FIN;
          endcase
        end
      end
      ST_SEED0:    state_d = ST_SEED1;
      ST_SEED1:    state_d = ST_SEED2;
      ST_SEED2:    state_d = ST_SEED3;
      ST_SEED3:    state_d = ST_START;
      ST_START:    state_d = ST_START_W;
      ST_START_W:  if (mod_done) state_d = ST_IDX;
      ST_IDX:      state_d = ST_IDX_W;
      ST_IDX_W:    if (mod_done) state_d = ST_RD;
      ST_RD:       state_d = ST_CHK;
      ST_CHK:      state_d = get_hit ? ST_FIN : ST_STEP_MUL;
      ST_STEP_MUL: state_d = ST_STEP_MOD;
      ST_STEP_MOD: state_d = ST_STEP_MOD_W;
      ST_STEP_MOD_W: begin
        if (mod_done) begin
          if ({1'b0, mod_rem} >= {2'b0, q}) begin
            state_d = (k_q < m) ? ST_STEP_MUL : ST_FIXQ;
          end else begin
            state_d = ST_ADV;
          end
        end
      end
      ST_FIXQ:     state_d = ST_FIXQ_W;
      ST_FIXQ_W:   if (mod_done) state_d = ST_ADV;
      ST_ADV:      state_d = (i_next >= q) ? ST_FIN : ST_IDX;
      ST_FIND_RD:  state_d = ST_FIND_CHK;
      ST_FIND_CHK: begin
        if (find_hit || (i_next >= q)) state_d = ST_FIN;
        else state_d = ST_FIND_RD;
      end
      ST_FIN:      if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx_q;
    ram_wdata = {1'b1, ram_rdata[WordW-2:0]};
    mul_a     = seed_q[31:0];
    mul_b     = RAND_MUL[31:0];
    mod_req   = '0;
    in_ready_o = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = {1'b1, {(WordW-1){1'b0}}};
      end
      ST_IDLE: in_ready_o = 1'b1;
      ST_DECODE: begin
        ram_addr  = IdxW'(put_shift);
        ram_we    = put_ok && (q != 11'd0)
                    && ((op_q == OP_PUT_VALID) || (op_q == OP_PUT_EMPTY));
        ram_wdata = {1'b0, put_pid, ntag_q, ntouch_q, noff_q, nphys_q};
      end
      ST_SEED1: mul_b = RAND_MUL[63:32];
      ST_SEED2: mul_a = seed_q[63:32];
      ST_START: begin
        mod_req.start    = 1'b1;
        mod_req.dividend = seed_q;
        mod_req.nbits    = 7'd64;
        mod_req.divisor  = {1'b0, q};
      end
      ST_IDX: begin
        mod_req.start    = 1'b1;
        mod_req.dividend = 64'({1'b0, n_q} + {2'b0, start_q});
        mod_req.nbits    = 7'd13;
        mod_req.divisor  = {1'b0, q};
      end
      ST_CHK: ram_we = get_hit;
      ST_STEP_MUL: begin
        mul_a = {20'd0, probe_mul_q};
        mul_b = {20'd0, n_q};
      end
      ST_STEP_MOD: begin
        mod_req.start    = 1'b1;
        mod_req.dividend = 64'(mul_p[24:0] + {13'd0, probe_inc_q});
        mod_req.nbits    = 7'd25;
        mod_req.divisor  = m;
      end
      ST_FIXQ: begin
        mod_req.start    = 1'b1;
        mod_req.dividend = {52'd0, n_q};
        mod_req.nbits    = 7'd12;
        mod_req.divisor  = {1'b0, q};
      end
      ST_FIND_RD, ST_FIND_CHK: ram_addr = IdxW'(i_q);
      ST_FIN: out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      seed_q        <= SEED_RESET;
      out_valid_q   <= 1'b0;
      page_count_q  <= 11'd1024;
      page_shift_q  <= 6'd20;
      probe_mul_q   <= 12'd1;
      probe_inc_q   <= 12'd1;
      probe_mod_q   <= 12'd1024;
      metric_mode_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + IdxW'(1);
      if (state_q == ST_SEED3) begin
        seed_q <= acc_q + {mul_p[31:0], 32'd0} + RAND_ADD;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PAGE_COUNT:  page_count_q  <= cfg_wdata_i[10:0];
          CFG_PAGE_SHIFT:  page_shift_q  <= cfg_wdata_i[5:0];
          CFG_PROBE_MUL:   probe_mul_q   <= cfg_wdata_i;
          CFG_PROBE_INC:   probe_inc_q   <= cfg_wdata_i;
          CFG_PROBE_MOD:   probe_mod_q   <= cfg_wdata_i;
          CFG_METRIC_MODE: metric_mode_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q       <= opcode_i;
      use_mask_q <= use_tag_mask_i;
      mask_q     <= tag_mask_i;
      npid_q     <= new_pattern_id_i;
      ntag_q     <= new_tag_i;
      ntouch_q   <= new_touch_i;
      noff_q     <= new_offset_i;
      nphys_q    <= new_phys_addr_i;
      laddr_q    <= lookup_address_i;
    end
    if (out_load) out_q <= res_q;
    case (state_q)
      ST_DECODE: begin
        res_q <= '0;
        i_q   <= '0;
        if ((q != 11'd0) && put_ok
            && ((op_q == OP_PUT_VALID) || (op_q == OP_PUT_EMPTY))) begin
          res_q.ok          <= 1'b1;
          res_q.entry_index <= 10'(put_shift);
          res_q.pattern_id  <= 16'(put_pid);
          res_q.tag         <= ntag_q;
          res_q.touch       <= ntouch_q;
          res_q.offset      <= noff_q;
          res_q.phys_addr   <= nphys_q;
        end
      end
      ST_SEED1: acc_q <= mul_p;
      ST_SEED2: acc_q <= acc_q + {mul_p[31:0], 32'd0};
      ST_START_W: begin
        start_q <= mod_rem[10:0];
        n_q     <= 12'd1;
      end
      ST_IDX_W: idx_q <= IdxW'(mod_rem);
      ST_CHK: begin
        k_q <= '0;
        if (get_hit) begin
          res_q.ok          <= 1'b1;
          res_q.entry_index <= 10'(idx_q);
          res_q.pattern_id  <= 16'(rd_pid);
          res_q.tag         <= rd_tag;
          res_q.offset      <= rd_off;
          res_q.phys_addr   <= rd_phys;
          if (!want_valid) res_q.touch <= rd_touch;
          else if (metric_mode_q) res_q.touch <= 32'(i_q);
          else res_q.touch <= rd_touch + 32'd1;
        end
      end
      ST_STEP_MOD_W: begin
        if (mod_done) begin
          n_q <= mod_rem;
          k_q <= k_q + 12'd1;
        end
      end
      ST_FIXQ_W: if (mod_done) n_q <= mod_rem;
      ST_ADV: i_q <= i_next;
      ST_FIND_CHK: begin
        if (find_hit) begin
          res_q.ok          <= 1'b1;
          res_q.entry_index <= 10'(i_q);
          res_q.pattern_id  <= 16'(rd_pid);
          res_q.tag         <= rd_tag;
          res_q.touch       <= rd_touch;
          res_q.offset      <= rd_off;
          res_q.phys_addr   <= rd_phys;
        end
        i_q <= i_next;
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = out_q.ok;
  assign entry_index_o = out_q.entry_index;
  assign pattern_id_o  = out_q.pattern_id;
  assign tag_o         = out_q.tag;
  assign touch_o       = out_q.touch;
  assign offset_o      = out_q.offset;
  assign phys_addr_o   = out_q.phys_addr;

endmodule
`default_nettype wire

@@ design/lpp_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module lpp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                we_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] addr_i,
  input  wire logic [Width-1:0]                    wdata_i,
  output logic      [Width-1:0]                    rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

@@ design/lpp_mul.sv @@
// Shared 32x32 multiplier with registered product.
`default_nettype none
module lpp_mul (
  input  wire logic        clk_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [63:0] p_o
);
  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end
endmodule
`default_nettype wire

@@ design/lpp_mod.sv @@
// Shared remainder unit: restoring division, one dividend bit per cycle.
`default_nettype none
module lpp_mod (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lpp_pkg::mod_req_t req_i,
  output logic                   done_o,
  output logic [11:0]            rem_o
);
  import lpp_pkg::*;

  logic        busy_q;
  logic [6:0]  cnt_q;
  logic [63:0] div_q;
  logic [11:0] dsr_q;
  logic [12:0] trial;

  assign trial = {rem_o, div_q[63]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.nbits;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      div_q <= req_i.dividend << (7'd64 - req_i.nbits);
      dsr_q <= req_i.divisor;
      rem_o <= '0;
    end else if (busy_q) begin
      div_q <= {div_q[62:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_o <= 12'(trial - {1'b0, dsr_q});
      end else begin
        rem_o <= trial[11:0];
      end
    end
  end
endmodule
`default_nettype wire

@@ test/locked_page_pool_random_probe_unit_test.sv @@
// Self-checking testbench of the locked page pool with random probing.
`default_nettype none
module locked_page_pool_random_probe_unit_test;
  import lpp_pkg::*;

  localparam int NPAGES = 1024;
  localparam int LIMIT_CYCLES = 20000000;

  typedef struct {
    logic [2:0]  op;
    logic        use_mask;
    logic [31:0] mask;
    logic [15:0] pid;
    logic [31:0] tag;
    logic [31:0] touch;
    logic [63:0] off;
    logic [63:0] phys;
    logic [63:0] addr;
  } pool_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  opcode_i = '0;
  logic        use_tag_mask_i = 1'b0;
  logic [31:0] tag_mask_i = '0;
  logic [15:0] new_pattern_id_i = '0;
  logic [31:0] new_tag_i = '0;
  logic [31:0] new_touch_i = '0;
  logic [63:0] new_offset_i = '0;
  logic [63:0] new_phys_addr_i = '0;
  logic [63:0] lookup_address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        ok_o;
  logic [9:0]  entry_index_o;
  logic [15:0] pattern_id_o;
  logic [31:0] tag_o;
  logic [31:0] touch_o;
  logic [63:0] offset_o;
  logic [63:0] phys_addr_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [11:0] cfg_wdata_i = '0;

  locked_page_pool_random_probe_unit u_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow copy of the pool
  logic        pool_lock  [NPAGES];
  logic [15:0] pool_pat   [NPAGES];
  logic [31:0] pool_tag   [NPAGES];
  logic [31:0] pool_touch [NPAGES];
  logic [63:0] pool_off   [NPAGES];
  logic [63:0] pool_phys  [NPAGES];
  logic [63:0] draw_seed;
  logic [10:0] sh_count;
  logic [5:0]  sh_shift;
  logic [11:0] sh_mul, sh_inc, sh_mod;
  logic        sh_mode;

  res_t expected_results[$];
  int   errors = 0;
  int   sent = 0, got = 0, gets_hit = 0;
  int   cycles = 0;
  bit   no_idle = 0;
  bit   long_hold = 0;
  int   hold_left = 0;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pool_size();
    return (sh_count < NPAGES) ? 64'(sh_count) : 64'(NPAGES);
  endfunction

  function automatic logic [63:0] probe_next(logic [63:0] n, logic [63:0] q);
    logic [63:0] m;
    logic [63:0] k;
    m = (sh_mod == 0) ? 64'd1 : 64'(sh_mod);
    n = (64'(sh_mul) * n + 64'(sh_inc)) % m;
    for (k = 0; k < m && n >= q; k++) n = (64'(sh_mul) * n + 64'(sh_inc)) % m;
    if (n >= q) n = n % q;
    return n;
  endfunction

  function automatic res_t entry_result(int idx, logic [31:0] touch);
    res_t r;
    r.ok = 1'b1;
    r.entry_index = idx[9:0];
    r.pattern_id = pool_pat[idx];
    r.tag = pool_tag[idx];
    r.touch = touch;
    r.offset = pool_off[idx];
    r.phys_addr = pool_phys[idx];
    return r;
  endfunction

  // apply one request to the shadow pool and return its result
  function automatic res_t apply_request(pool_req_t rq);
    res_t r;
    logic [63:0] q, start, n, idx, sz;
    logic [15:0] pid;
    bit want_valid;
    r = '0;
    q = pool_size();
    if (q == 0) return r;
    case (rq.op)
      OP_GET_VALID, OP_GET_EMPTY: begin
        want_valid = (rq.op == OP_GET_VALID);
        draw_seed = RAND_MUL * draw_seed + RAND_ADD;
        start = draw_seed % q;
        n = 1;
        for (longint i = 0; i < q; i++) begin
          idx = (n + start) % q;
          n = probe_next(n, q);
          if ((pool_pat[idx] != 0) != want_valid) continue;
          if (rq.use_mask && (pool_tag[idx] & rq.mask) == 0) continue;
          if (pool_lock[idx]) continue;
          pool_lock[idx] = 1'b1;
          if (!want_valid) return entry_result(int'(idx), pool_touch[idx]);
          return entry_result(int'(idx), sh_mode ? 32'(i) : pool_touch[idx] + 32'd1);
        end
      end
      OP_PUT_VALID, OP_PUT_EMPTY: begin
        pid = (rq.op == OP_PUT_EMPTY) ? 16'd0 : rq.pid;
        idx = rq.off >> sh_shift;
        if (rq.op == OP_PUT_VALID && pid == 0) return r;
        if (idx >= q) return r;
        pool_pat[idx] = pid;
        pool_tag[idx] = rq.tag;
        pool_touch[idx] = rq.touch;
        pool_off[idx] = rq.off;
        pool_phys[idx] = rq.phys;
        pool_lock[idx] = 1'b0;
        return entry_result(int'(idx), rq.touch);
      end
      OP_FIND: begin
        sz = 64'd1 << sh_shift;
        for (int i = 0; i < q; i++)
          if (pool_phys[i] <= rq.addr && rq.addr - pool_phys[i] < sz)
            return entry_result(i, pool_touch[i]);
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    for (int i = 0; i < NPAGES; i++) begin
      pool_lock[i] = 1'b1;
      pool_pat[i] = '0;
      pool_tag[i] = '0;
      pool_touch[i] = '0;
      pool_off[i] = '0;
      pool_phys[i] = '0;
    end
    draw_seed = SEED_RESET;
    sh_count = 11'd1024;
    sh_shift = 6'd20;
    sh_mul = 12'd1;
    sh_inc = 12'd1;
    sh_mod = 12'd1024;
    sh_mode = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_results.size());
      $display("locked_page_pool_random_probe_unit_test: FAIL");
      $finish;
    end
  end

  // result side: random stalls, occasional long ones, and one forced hold-off
  always @(posedge clk_i) begin
    if (long_hold) begin
      long_hold = 0;
      hold_left <= 600;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (no_idle) begin
      out_ready_i <= 1'b1;
    end else if ($urandom_range(0, 49) == 0) begin
      hold_left <= $urandom_range(10, 60);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual ok=%b index=%0d",
                 $time, ok_o, entry_index_o);
      end else begin
        e = expected_results.pop_front();
        check_field("ok", 64'(e.ok), 64'(ok_o));
        check_field("entry_index", 64'(e.entry_index), 64'(entry_index_o));
        check_field("pattern_id", 64'(e.pattern_id), 64'(pattern_id_o));
        check_field("tag", 64'(e.tag), 64'(tag_o));
        check_field("touch", 64'(e.touch), 64'(touch_o));
        check_field("offset", e.offset, offset_o);
        check_field("phys_addr", e.phys_addr, phys_addr_o);
      end
    end
  end

  // offer one request, hold it until taken, and record its result
  task automatic send_request(pool_req_t rq);
    int gap;
    res_t r;
    gap = 0;
    if (!no_idle) begin
      if ($urandom_range(0, 14) == 0) gap = $urandom_range(8, 40);
      else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= rq.op;
    use_tag_mask_i <= rq.use_mask;
    tag_mask_i <= rq.mask;
    new_pattern_id_i <= rq.pid;
    new_tag_i <= rq.tag;
    new_touch_i <= rq.touch;
    new_offset_i <= rq.off;
    new_phys_addr_i <= rq.phys;
    lookup_address_i <= rq.addr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    r = apply_request(rq);
    if (r.ok && (rq.op == OP_GET_VALID || rq.op == OP_GET_EMPTY)) gets_hit++;
    expected_results.push_back(r);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // hold the write enable high; the caller drops it after the last write
  task automatic cfg_write(logic [2:0] idx, logic [11:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_PAGE_COUNT:  sh_count = val[10:0];
      CFG_PAGE_SHIFT:  sh_shift = val[5:0];
      CFG_PROBE_MUL:   sh_mul = val;
      CFG_PROBE_INC:   sh_inc = val;
      CFG_PROBE_MOD:   sh_mod = val;
      CFG_METRIC_MODE: sh_mode = val[0];
      default: ;
    endcase
  endtask

  task automatic configure(int cnt, int shift, int mul, int inc, int md, int mode);
    wait_drained();
    cfg_write(CFG_PAGE_COUNT, 12'(cnt));
    cfg_write(CFG_PAGE_SHIFT, 12'(shift));
    cfg_write(CFG_PROBE_MUL, 12'(mul));
    cfg_write(CFG_PROBE_INC, 12'(inc));
    cfg_write(CFG_PROBE_MOD, 12'(md));
    cfg_write(CFG_METRIC_MODE, 12'(mode));
    cfg_we_i <= 1'b0;
  endtask

  function automatic pool_req_t noise_req(logic [2:0] op);
    pool_req_t rq;
    rq.op = op;
    rq.use_mask = $urandom_range(0, 1);
    rq.mask = $urandom;
    rq.pid = $urandom;
    rq.tag = $urandom;
    rq.touch = $urandom;
    rq.off = rand64();
    rq.phys = rand64();
    rq.addr = rand64();
    return rq;
  endfunction

  function automatic pool_req_t put_req(logic [2:0] op, int idx, logic [15:0] pid);
    pool_req_t rq;
    logic [63:0] low_mask;
    rq = noise_req(op);
    low_mask = (64'd1 << sh_shift) - 64'd1;
    rq.pid = pid;
    rq.off = (64'(idx) << sh_shift) | (rand64() & low_mask);
    return rq;
  endfunction

  function automatic pool_req_t find_near(int idx);
    pool_req_t rq;
    rq = noise_req(OP_FIND);
    case ($urandom_range(0, 3))
      0: rq.addr = pool_phys[idx];
      1: rq.addr = pool_phys[idx] + ((64'd1 << sh_shift) - 64'd1);
      2: rq.addr = pool_phys[idx] + (rand64() & ((64'd1 << sh_shift) - 64'd1));
      default: ;
    endcase
    return rq;
  endfunction

  // reset config: every page locked, so a get scans the whole pool and fails
  task automatic test_after_reset();
    pool_req_t rq;
    rq = noise_req(OP_GET_EMPTY);
    send_request(rq);
    rq = noise_req(OP_FIND);
    rq.addr = 64'd0;
    send_request(rq);
    send_request(put_req(OP_PUT_VALID, 1023, 16'hffff));
    send_request(find_near(1023));
  endtask

  task automatic test_fields_and_ops();
    pool_req_t rq;
    configure(8, 0, 5, 3, 8, 0);
    rq = put_req(OP_PUT_VALID, 0, 16'hffff);
    rq.touch = 32'hffff_ffff;
    rq.tag = 32'hffff_ffff;
    rq.phys = 64'hffff_ffff_ffff_ffff;
    send_request(rq);
    send_request(put_req(OP_PUT_VALID, 1, 16'h0000));
    send_request(put_req(OP_PUT_VALID, 8, 16'h0001));
    rq = put_req(OP_PUT_VALID, 2, 16'h0001);
    rq.tag = 32'h0000_0001;
    rq.touch = 32'd0;
    rq.phys = 64'd0;
    send_request(rq);
    send_request(put_req(OP_PUT_EMPTY, 3, 16'h1234));
    send_request(put_req(OP_PUT_EMPTY, 3, 16'h4321));
    rq = noise_req(OP_GET_VALID);
    rq.use_mask = 1'b1;
    rq.mask = 32'h8000_0000;
    send_request(rq);
    rq.mask = 32'd0;
    send_request(rq);
    rq.use_mask = 1'b0;
    send_request(rq);
    send_request(noise_req(OP_GET_EMPTY));
    rq = noise_req(OP_FIND);
    rq.addr = 64'hffff_ffff_ffff_ffff;
    send_request(rq);
    rq.addr = 64'd0;
    send_request(rq);
    send_request(noise_req(3'd5));
    send_request(noise_req(3'd6));
    send_request(noise_req(3'd7));
    configure(8, 0, 5, 3, 8, 1);
    send_request(put_req(OP_PUT_VALID, 5, 16'h00aa));
    send_request(put_req(OP_PUT_VALID, 6, 16'h00bb));
    send_request(noise_req(OP_GET_VALID));
    send_request(noise_req(OP_GET_VALID));
  endtask

  task automatic test_probe_corners();
    // step order that never lands inside the pool: falls back to modulo
    configure(1, 3, 1, 2, 4, 1);
    send_request(put_req(OP_PUT_VALID, 0, 16'h0007));
    send_request(noise_req(OP_GET_VALID));
    // zero modulus behaves as one
    configure(4, 2, 3, 1, 0, 0);
    for (int i = 0; i < 4; i++) send_request(put_req(OP_PUT_VALID, i, 16'(i + 1)));
    send_request(noise_req(OP_GET_VALID));
    send_request(noise_req(OP_GET_VALID));
    // modulus, multiplier and increment of 2048 with a one-entry pool
    configure(1, 40, 2048, 2048, 2048, 0);
    send_request(put_req(OP_PUT_VALID, 0, 16'h0100));
    send_request(noise_req(OP_GET_VALID));
    send_request(find_near(0));
    // empty pool: everything fails
    configure(0, 0, 1, 1, 1, 0);
    send_request(put_req(OP_PUT_VALID, 0, 16'h0001));
    send_request(noise_req(OP_GET_VALID));
    send_request(noise_req(OP_FIND));
    // count above the table size clamps; no gets here, they would scan it all
    configure(2047, 40, 1, 1, 2048, 0);
    send_request(put_req(OP_PUT_VALID, 1023, 16'h0055));
    send_request(put_req(OP_PUT_VALID, 1024, 16'h0055));
    send_request(find_near(1023));
  endtask

  task automatic test_random_traffic(int total);
    int q, idx, done, pick;
    pool_req_t rq;
    done = 0;
    while (done < total) begin
      q = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 16);
      configure(q, $urandom_range(0, 40), $urandom_range(1, 2048), $urandom_range(1, 2048),
                q + $urandom_range(0, 6), $urandom_range(0, 1));
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 70 && done < total; k++) begin
        idx = $urandom_range(0, q - 1);
        pick = $urandom_range(0, 99);
        if (pick < 35) rq = put_req(OP_PUT_VALID, idx, 16'($urandom_range(0, 20) == 0 ? 0 :
                                    $urandom_range(1, 65535)));
        else if (pick < 45) rq = put_req(OP_PUT_EMPTY, idx, 16'($urandom));
        else if (pick < 68) rq = noise_req(OP_GET_VALID);
        else if (pick < 78) rq = noise_req(OP_GET_EMPTY);
        else if (pick < 92) rq = find_near(idx);
        else if (pick < 95) rq = put_req(OP_PUT_VALID, q + $urandom_range(0, 3), 16'h0001);
        else rq = noise_req(3'($urandom_range(0, 7)));
        if (rq.op == OP_GET_VALID || rq.op == OP_GET_EMPTY) begin
          // sparse masks make the tag filter bite
          if ($urandom_range(0, 1) == 0) rq.mask = 32'd1 << $urandom_range(0, 31);
        end
        send_request(rq);
        done++;
      end
      no_idle = 0;
    end
  endtask

  task automatic test_backpressure();
    configure(16, 4, 5, 1, 16, 0);
    long_hold = 1;
    for (int i = 0; i < 30; i++) send_request(put_req(OP_PUT_VALID, i % 16, 16'(i + 1)));
    for (int i = 0; i < 10; i++) send_request(noise_req(OP_GET_VALID));
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_after_reset();
    test_fields_and_ops();
    test_probe_corners();
    test_backpressure();
    test_random_traffic(680);
    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("Sent %0d requests, checked %0d results, %0d gets found a page.",
             sent, got, gets_hit);
    $display("Covered reset state, all opcodes, probe corners, empty pool and back-pressure.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("locked_page_pool_random_probe_unit_test: PASS");
    end else begin
      $display("locked_page_pool_random_probe_unit_test: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ locked_page_pool_random_probe_unit.f @@
design/lpp_pkg.sv
design/lpp_ram.sv
design/lpp_mul.sv
design/lpp_mod.sv
design/locked_page_pool_random_probe_unit.sv
test/locked_page_pool_random_probe_unit_test.sv
